[hw/rtl/bdlr_pkg.sv]
// ----------------------------------------------------------------------------
// bdlr_pkg
// Shared types and constants of the button debouncer with long press and
// auto-repeat: event kinds, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdlr_pkg;

    // Widths of the stored counts and of the ports.
    localparam int FILT_W    = 7;
    localparam int CNT_W     = 16;
    localparam int CODE_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd1;

    // Register reset values.
    localparam logic [CNT_W-1:0] HOLD_TIME_RST     = 16'd1000;
    localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 16'd0;

    // Event kinds, the low part of an event code.
    typedef enum logic [2:0] {
        KIND_PRESS   = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_SHORT   = 3'd4
    } kind_t;

    // Up to two events raised by one tick, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        kind_t      k0;
        kind_t      k1;
    } evt_pair_t;

    // Tracker status seen by the top level.
    typedef struct packed {
        logic              pressed;
        logic [FILT_W-1:0] filt;
    } trk_status_t;

endpackage

`default_nettype wire

[hw/rtl/bdlr_track.sv]
// ----------------------------------------------------------------------------
// bdlr_track
// Debounce filter, press state, long and repeat counters, and the two
// configuration registers. Updates its state once per processed tick and its
// registers on each write, and reports the events each tick raises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdlr_track #(
    parameter int FILTER_TIME = 30,
    parameter int STEP        = 5
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire [bdlr_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire [bdlr_pkg::CNT_W-1:0]        cfg_wdata,
    input  wire                              tick,
    input  wire                              pin_level,
    output bdlr_pkg::evt_pair_t              evts,
    output bdlr_pkg::trk_status_t            status
);

    localparam logic [bdlr_pkg::FILT_W-1:0] FT  = bdlr_pkg::FILT_W'(FILTER_TIME);
    localparam logic [bdlr_pkg::FILT_W-1:0] TOP = bdlr_pkg::FILT_W'(2 * FILTER_TIME);
    localparam logic [bdlr_pkg::FILT_W:0]   TOP_X  = (bdlr_pkg::FILT_W + 1)'(2 * FILTER_TIME);
    localparam logic [bdlr_pkg::FILT_W:0]   STEP_X = (bdlr_pkg::FILT_W + 1)'(STEP);
    localparam logic [bdlr_pkg::FILT_W-1:0] STEP_F = bdlr_pkg::FILT_W'(STEP);
    localparam logic [bdlr_pkg::CNT_W-1:0]  STEP_C = bdlr_pkg::CNT_W'(STEP);

    logic [bdlr_pkg::CNT_W-1:0]  hold_time_reg, hold_time_next;
    logic [bdlr_pkg::CNT_W-1:0]  repeat_period_reg, repeat_period_next;
    logic                        pressed_reg, pressed_next;
    logic [bdlr_pkg::FILT_W-1:0] filt_reg, filt_next;
    logic [bdlr_pkg::CNT_W-1:0]  long_reg, long_next;
    logic [bdlr_pkg::CNT_W-1:0]  rep_reg, rep_next;

    logic [bdlr_pkg::FILT_W:0]   filt_up;
    logic [bdlr_pkg::CNT_W-1:0]  long_up;
    logic [bdlr_pkg::CNT_W-1:0]  rep_up;
    logic [1:0]                  n;
    bdlr_pkg::kind_t             k0, k1;

    assign filt_up = {1'b0, filt_reg} + STEP_X;
    assign long_up = long_reg + STEP_C;
    assign rep_up  = rep_reg + STEP_C;

    // Next state and raised events for one tick; configuration writes are to come
    // only while no tick is in flight, which this block does not enforce.
    always_comb begin
        hold_time_next     = hold_time_reg;
        repeat_period_next = repeat_period_reg;
        pressed_next       = pressed_reg;
        filt_next          = filt_reg;
        long_next          = long_reg;
        rep_next           = rep_reg;
        n                  = 2'd0;
        k0                 = bdlr_pkg::KIND_PRESS;
        k1                 = bdlr_pkg::KIND_PRESS;

        if (cfg_we) begin
            case (cfg_idx)
                bdlr_pkg::REG_HOLD_TIME: begin
                    hold_time_next = cfg_wdata;
                end
                bdlr_pkg::REG_REPEAT_PERIOD: begin
                    repeat_period_next = cfg_wdata;
                    rep_next           = '0;
                end
                default: begin
                end
            endcase
        end

        if (tick) begin
            if (!pin_level) begin
                // Pin active: climb toward the top, then run the press logic.
                if (filt_reg < FT) begin
                    filt_next = FT;
                end else if (filt_reg < TOP) begin
                    filt_next = (filt_up > TOP_X) ? TOP : filt_up[bdlr_pkg::FILT_W-1:0];
                end else begin
                    if (!pressed_reg) begin
                        pressed_next = 1'b1;
                        k0           = bdlr_pkg::KIND_PRESS;
                        n            = 2'd1;
                    end
                    if (hold_time_reg != '0) begin
                        if (long_reg < hold_time_reg) begin
                            long_next = long_up;
                            if (long_up == hold_time_reg) begin
                                if (n == 2'd0) k0 = bdlr_pkg::KIND_LONG;
                                else           k1 = bdlr_pkg::KIND_LONG;
                                n = n + 2'd1;
                            end
                        end else if (repeat_period_reg != '0) begin
                            rep_next = rep_up;
                            if (rep_up >= repeat_period_reg) begin
                                rep_next = '0;
                                if (n == 2'd0) k0 = bdlr_pkg::KIND_PRESS;
                                else           k1 = bdlr_pkg::KIND_PRESS;
                                n = n + 2'd1;
                            end
                        end
                    end
                end
            end else begin
                // Pin inactive: fall toward zero, then release.
                if (filt_reg > FT) begin
                    filt_next = FT;
                end else if (filt_reg != '0) begin
                    filt_next = (filt_reg > STEP_F) ? (filt_reg - STEP_F) : '0;
                end else if (pressed_reg) begin
                    pressed_next = 1'b0;
                    long_next    = '0;
                    rep_next     = '0;
                    if (hold_time_reg != '0 && long_reg < hold_time_reg) begin
                        k0 = bdlr_pkg::KIND_SHORT;
                        k1 = bdlr_pkg::KIND_RELEASE;
                        n  = 2'd2;
                    end else begin
                        k0 = bdlr_pkg::KIND_RELEASE;
                        n  = 2'd1;
                    end
                end
            end
        end
    end

    // State and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg     <= bdlr_pkg::HOLD_TIME_RST;
            repeat_period_reg <= bdlr_pkg::REPEAT_PERIOD_RST;
            pressed_reg       <= 1'b0;
            filt_reg          <= '0;
            long_reg          <= '0;
            rep_reg           <= '0;
        end else begin
            hold_time_reg     <= hold_time_next;
            repeat_period_reg <= repeat_period_next;
            pressed_reg       <= pressed_next;
            filt_reg          <= filt_next;
            long_reg          <= long_next;
            rep_reg           <= rep_next;
        end
    end

    assign evts.cnt       = n;
    assign evts.k0        = k0;
    assign evts.k1        = k1;
    assign status.pressed = pressed_reg;
    assign status.filt    = filt_reg;

endmodule

`default_nettype wire

[hw/rtl/bdlr_outq.sv]
// ----------------------------------------------------------------------------
// bdlr_outq
// Two-entry result buffer. Loads the events of one tick at once and hands
// them out one word at a time, marking the final one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdlr_outq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  bdlr_pkg::evt_pair_t  evts,
    output logic                 can_load,
    output logic                 m_valid,
    input  wire                  m_ready,
    output bdlr_pkg::kind_t      head_kind,
    output logic                 m_last
);

    logic [1:0]      rem_reg, rem_next;
    bdlr_pkg::kind_t head_reg, head_next;
    bdlr_pkg::kind_t tail_reg, tail_next;

    // Room for a new pair once the buffer empties in this cycle.
    assign can_load = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_ready);

    always_comb begin
        rem_next  = rem_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (m_valid && m_ready) begin
            rem_next  = rem_reg - 2'd1;
            head_next = tail_reg;
        end
        if (load) begin
            rem_next  = evts.cnt;
            head_next = evts.k0;
            tail_next = evts.k1;
        end
    end

    // Count of words left; reset empties the buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    // Event kinds carry no reset.
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid   = (rem_reg != 2'd0);
    assign m_last    = (rem_reg == 2'd1);
    assign head_kind = head_reg;

endmodule

`default_nettype wire

[hw/rtl/button_debounce_long_repeat_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_repeat_core
// Debounces one active-low button and reports press, release, long press,
// auto-repeat press and short press events.
// ----------------------------------------------------------------------------
// Usage: each word on the s_ channel is one scan tick carrying the raw pin
// level (0 = pressed). Each word on the m_ channel is one event, with
// m_event_code = 4*BUTTON_ID + kind and m_last set on the final event of a
// tick. A tick raises zero, one or two events; a tick without events sends
// nothing.
// Order: a tick is registered on accept, processed once the result buffer can
// take its events, and its first event is then presented from the buffer.
// Throughput: one tick per cycle while the receiver keeps up. A tick that
// raises two events holds the next one back while the two-entry result
// buffer drains one word per cycle.
// Configuration: cfg_ready is always high; cfg_index 0 is the long-press
// time, 1 is repeat_period (its write also clears the repeat count), others
// are ignored. Write only while idle.
// Reset: clears the filter, counters and buffers; the long-press time becomes
// 1000 and repeat_period 0. When the receiver stalls, events wait in the
// buffer and s_ready falls once the tick register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_repeat_core #(
    parameter int FILTER_TIME = 30,
    parameter int STEP        = 5,
    parameter int BUTTON_ID   = 0
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [bdlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [bdlr_pkg::CNT_W-1:0]        cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_pin_level,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [bdlr_pkg::CODE_W-1:0]      m_event_code,
    output logic                             m_last
);

    localparam logic [bdlr_pkg::CODE_W-1:0] CODE_BASE = bdlr_pkg::CODE_W'(4 * BUTTON_ID);

    logic                  tick_vld_reg, tick_vld_next;
    logic                  pin_reg;
    logic                  fire;
    logic                  can_load;
    bdlr_pkg::evt_pair_t   evts;
    bdlr_pkg::trk_status_t status;
    bdlr_pkg::kind_t       head_kind;

    assign cfg_ready = 1'b1;

    // Tick register: advances when the result buffer can take its events.
    assign fire          = tick_vld_reg && can_load;
    assign s_ready       = !tick_vld_reg || fire;
    assign tick_vld_next = (s_valid && s_ready) ? 1'b1 : (tick_vld_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_vld_reg <= 1'b0;
        end else begin
            tick_vld_reg <= tick_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pin_reg <= s_pin_level;
        end
    end

    bdlr_track #(
        .FILTER_TIME (FILTER_TIME),
        .STEP        (STEP)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .tick      (fire),
        .pin_level (pin_reg),
        .evts      (evts),
        .status    (status)
    );

    bdlr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .evts      (evts),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head_kind (head_kind),
        .m_last    (m_last)
    );

    assign m_event_code = CODE_BASE + bdlr_pkg::CODE_W'(head_kind);

    // The filter count never passes twice the filter time.
    a_filt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.filt <= bdlr_pkg::FILT_W'(2 * FILTER_TIME))
        else $error("filter count above its top");

    // A word that is not the final one of its tick is followed by another.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("second event of a tick missing");

    // Reset leaves no event pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("event pending after reset");

    // A release event only ever goes out while the button reads released.
    a_release_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && head_kind == bdlr_pkg::KIND_RELEASE |-> !status.pressed)
        else $error("release event while pressed");

endmodule

`default_nettype wire

[tb/sv/bdlr_event_checker.sv]
// ----------------------------------------------------------------------------
// bdlr_event_checker
// Watches the register, tick and event channels of the button debouncer. It
// keeps its own model of the filter, press state, long and repeat counts, and
// queues the events that each accepted tick should raise. Every event word is
// compared field by field with the oldest queued event, and each mismatch is
// reported and counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlr_event_checker #(
    parameter int FILTER_TIME = 30,
    parameter int STEP        = 5,
    parameter int BUTTON_ID   = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bdlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdlr_pkg::CNT_W-1:0]     cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_pin_level,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [bdlr_pkg::CODE_W-1:0]    m_event_code,
    input  logic                           m_last,
    output int                             n_errors,
    output int                             n_pending
);

    localparam int FILT_TOP = 2 * FILTER_TIME;

    // One expected event word.
    typedef struct packed {
        logic [bdlr_pkg::CODE_W-1:0] code;
        logic                        last;
    } event_word_t;

    event_word_t       pending_events[$];

    // Model state and register copies.
    logic                        pressed;
    logic [bdlr_pkg::FILT_W-1:0] filt;
    logic [bdlr_pkg::CNT_W-1:0]  hold_cnt;
    logic [bdlr_pkg::CNT_W-1:0]  rep_cnt;
    logic [bdlr_pkg::CNT_W-1:0]  hold_time;
    logic [bdlr_pkg::CNT_W-1:0]  rep_period;

    initial n_errors = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    always @(posedge aclk) begin : track
        bdlr_pkg::kind_t raised[$];
        event_word_t     want;
        int              filt_sum;
        if (!aresetn) begin
            pressed    = 1'b0;
            filt       = '0;
            hold_cnt   = '0;
            rep_cnt    = '0;
            hold_time  = bdlr_pkg::HOLD_TIME_RST;
            rep_period = bdlr_pkg::REPEAT_PERIOD_RST;
            pending_events.delete();
        end else begin
            // Register writes; unknown indexes are ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bdlr_pkg::REG_HOLD_TIME: begin
                        hold_time = cfg_data;
                    end
                    bdlr_pkg::REG_REPEAT_PERIOD: begin
                        rep_period = cfg_data;
                        rep_cnt    = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // One scan tick: update the debounce state and collect its events.
            if (s_valid && s_ready) begin
                raised.delete();
                if (s_pin_level == 1'b0) begin
                    if (filt < FILTER_TIME) begin
                        filt = bdlr_pkg::FILT_W'(FILTER_TIME);
                    end else if (filt < FILT_TOP) begin
                        filt_sum = int'(filt) + STEP;
                        if (filt_sum > FILT_TOP)
                            filt = bdlr_pkg::FILT_W'(FILT_TOP);
                        else
                            filt = bdlr_pkg::FILT_W'(filt_sum);
                    end else begin
                        if (!pressed) begin
                            pressed = 1'b1;
                            raised.push_back(bdlr_pkg::KIND_PRESS);
                        end
                        // Long press first, then auto-repeat once it is past.
                        if (hold_time != '0) begin
                            if (hold_cnt < hold_time) begin
                                hold_cnt = hold_cnt + bdlr_pkg::CNT_W'(STEP);
                                if (hold_cnt == hold_time)
                                    raised.push_back(bdlr_pkg::KIND_LONG);
                            end else if (rep_period != '0) begin
                                rep_cnt = rep_cnt + bdlr_pkg::CNT_W'(STEP);
                                if (rep_cnt >= rep_period) begin
                                    rep_cnt = '0;
                                    raised.push_back(bdlr_pkg::KIND_PRESS);
                                end
                            end
                        end
                    end
                end else begin
                    if (filt > FILTER_TIME) begin
                        filt = bdlr_pkg::FILT_W'(FILTER_TIME);
                    end else if (filt != '0) begin
                        filt = (filt > STEP) ? filt - bdlr_pkg::FILT_W'(STEP) : '0;
                    end else if (pressed) begin
                        // A release before the long press reached gets a short event.
                        pressed = 1'b0;
                        if (hold_time != '0 && hold_cnt < hold_time)
                            raised.push_back(bdlr_pkg::KIND_SHORT);
                        raised.push_back(bdlr_pkg::KIND_RELEASE);
                        hold_cnt = '0;
                        rep_cnt  = '0;
                    end
                end
                foreach (raised[i]) begin
                    want.code = bdlr_pkg::CODE_W'(4 * BUTTON_ID + int'(raised[i]));
                    want.last = (i == raised.size() - 1);
                    pending_events.push_back(want);
                end
            end

            // Compare each delivered event word with the oldest expected one.
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event code %0d, last %0b",
                                              m_event_code, m_last));
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_code !== want.code)
                        report_mismatch($sformatf("event_code %0d, expected %0d",
                                                  m_event_code, want.code));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_last, want.last));
                end
            end
        end
        n_pending <= pending_events.size();
    end

endmodule

[tb/sv/button_debounce_long_repeat_core_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_repeat_core_tb
// Drives scan ticks and register writes into the button debouncer and lets
// the event checker judge every event word. A short directed sequence covers
// press, long and auto-repeat events and spare register indexes; then random
// press gestures with bounce and noise run under several register settings
// and three flow-control phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_repeat_core_tb;

    localparam int FILTER_TIME = 30;
    localparam int STEP        = 5;
    localparam int BUTTON_ID   = 0;
    localparam int N_SEG       = 9;
    localparam int SEG_TICKS   = 30;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYC  = 8;

    // Indexes with no register behind them.
    localparam logic [bdlr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bdlr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [bdlr_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [bdlr_pkg::CNT_W-1:0]     cfg_data    = '0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic                           s_pin_level = 1'b1;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [bdlr_pkg::CODE_W-1:0]    m_event_code;
    logic                           m_last;

    int n_errors;
    int n_pending;
    int n_ticks  = 0;
    int src_idle = 6;
    int dst_idle = 66;

    button_debounce_long_repeat_core #(
        .FILTER_TIME (FILTER_TIME),
        .STEP        (STEP),
        .BUTTON_ID   (BUTTON_ID)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pin_level  (s_pin_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_last       (m_last)
    );

    bdlr_event_checker #(
        .FILTER_TIME (FILTER_TIME),
        .STEP        (STEP),
        .BUTTON_ID   (BUTTON_ID)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pin_level  (s_pin_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_last       (m_last),
        .n_errors     (n_errors),
        .n_pending    (n_pending)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_idle);
    end

    // Hard limit on the run time.
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sends one tick word, with random gaps before it; valid stays high after
    // acceptance until the next call or a pause lowers it.
    task automatic send_tick(input logic level);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= level;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_ticks++;
        @(negedge aclk);
    endtask

    // Writes one register word and then drops valid before returning.
    task automatic write_reg(input logic [bdlr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlr_pkg::CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops the ticks, waits for every expected event, then lets the pipeline
    // settle so that ticks without events are done as well.
    task automatic wait_idle();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (n_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // One press gesture: optional bounce, a hold with rare glitches, bounce,
    // and a release long enough to finish. Some gestures are plain noise.
    task automatic drive_gesture();
        int n_hold;
        int n_rel;
        int n_bounce;
        if ($urandom_range(0, 99) < 15) begin
            n_hold = $urandom_range(1, 12);
            repeat (n_hold) send_tick(1'($urandom_range(0, 1)));
        end else begin
            n_bounce = $urandom_range(0, 3);
            repeat (n_bounce) send_tick(1'($urandom_range(0, 1)));
            n_hold = 8 + $urandom_range(0, 24);
            repeat (n_hold) send_tick(($urandom_range(0, 99) < 3) ? 1'b1 : 1'b0);
            n_bounce = $urandom_range(0, 3);
            repeat (n_bounce) send_tick(1'($urandom_range(0, 1)));
            n_rel = 8 + $urandom_range(0, 4);
            repeat (n_rel) send_tick(1'b1);
        end
    endtask

    initial begin : stimulus
        logic [bdlr_pkg::CNT_W-1:0] lt;
        logic [bdlr_pkg::CNT_W-1:0] rp;
        int                         seg_end;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: long press on the press tick, repeat on every later tick,
        // a bounce while pressed, then release. Spare indexes must be ignored.
        write_reg(bdlr_pkg::REG_HOLD_TIME, 16'd5);
        write_reg(bdlr_pkg::REG_REPEAT_PERIOD, 16'd5);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        repeat (9) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (8) send_tick(1'b1);
        wait_idle();

        // Random gestures over several register settings and idle phases.
        for (int seg = 0; seg < N_SEG; seg++) begin
            if (seg < 3) begin
                src_idle = 6;
                dst_idle = 66;
            end else if (seg < 6) begin
                src_idle = 66;
                dst_idle = 6;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            case (seg)
                0:       begin lt = 16'd0;     rp = 16'd0;     end
                1:       begin lt = 16'd5;     rp = 16'd1;     end
                2:       begin lt = 16'd12;    rp = 16'd7;     end
                3:       begin lt = 16'd65535; rp = 16'd65535; end
                4:       begin lt = 16'd20;    rp = 16'd0;     end
                5:       begin lt = 16'd1000;  rp = 16'd5;     end
                6:       begin lt = 16'd25;    rp = 16'd10;    end
                7:       begin lt = 16'd1;     rp = 16'd3;     end
                default: begin
                    lt = 16'($urandom_range(1, 60));
                    rp = 16'($urandom_range(0, 20));
                end
            endcase
            write_reg(bdlr_pkg::REG_HOLD_TIME, lt);
            write_reg(bdlr_pkg::REG_REPEAT_PERIOD, rp);
            write_reg(REG_SPARE_A, 16'($urandom));
            seg_end = n_ticks + SEG_TICKS;
            while (n_ticks < seg_end)
                drive_gesture();
            wait_idle();
        end

        if (n_errors == 0 && n_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[button_debounce_long_repeat_core.f]
hw/rtl/bdlr_pkg.sv
hw/rtl/bdlr_track.sv
hw/rtl/bdlr_outq.sv
hw/rtl/button_debounce_long_repeat_core.sv
tb/sv/bdlr_event_checker.sv
tb/sv/button_debounce_long_repeat_core_tb.sv
